/* sv/cbor_hdr_pkg.sv */
// ----------------------------------------------------------------------------
// cbor_hdr_pkg
// shared types and constants of the cbor item header decoder
// ----------------------------------------------------------------------------
package cbor_hdr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned KindW  = 4;
  localparam int unsigned ErrW   = 3;
  localparam int unsigned LeftW  = 4;

  localparam logic [7:0] BreakByte  = 8'hFF;
  localparam logic [4:0] ShortMax   = 5'd23;
  localparam logic [4:0] MinorOne   = 5'd24;
  localparam logic [4:0] MinorEight = 5'd27;
  localparam logic [4:0] MinorIndef = 5'd31;
  localparam logic [LeftW-1:0] MaxArgBytes = 4'd8;

  typedef enum logic [2:0] {
    MAJ_UINT   = 3'd0,
    MAJ_NEGINT = 3'd1,
    MAJ_BYTES  = 3'd2,
    MAJ_TEXT   = 3'd3,
    MAJ_ARRAY  = 3'd4,
    MAJ_MAP    = 3'd5,
    MAJ_TAG    = 3'd6,
    MAJ_SIMPLE = 3'd7
  } major_t;

  localparam logic [KindW-1:0] KindBreak = 4'd8;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE  = 3'd0,
    ERR_PARSE = 3'd1,
    ERR_FLOAT = 3'd2,
    ERR_INDEF = 3'd3,
    ERR_RANGE = 3'd4
  } err_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic              indef;
    logic [ValueW-1:0] value;
    err_t              err;
  } res_t;

endpackage

/* sv/cbor_hdr_top.sv */
// ----------------------------------------------------------------------------
// cbor_item_header_decoder_top
// cbor initial byte and argument decoder, one stream byte per transfer
// ----------------------------------------------------------------------------
//
//  channel  handshake             payload
//  -------  --------------------  -------------------------------------------
//  in       in_valid / in_stall   data_byte
//  out      out_valid / out_stall item_kind, indef_length, item_value,
//                                 error_code
//
//  one byte per cycle sustained unless the result register stalls; a header
//  result moves from the input register through the result register
//  headers of 24..27 and every argument byte but the last produce no result
//  rst is synchronous; it empties both registers and drops back to waiting
//  for a header byte
//  a stalled full result register stops the input register, which then
//  raises in_stall; a free or draining result register never stalls
//
module cbor_item_header_decoder_top
  import cbor_hdr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ByteW-1:0]  data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KindW-1:0]  item_kind,
  output logic              indef_length,
  output logic [ValueW-1:0] item_value,
  output logic [ErrW-1:0]   error_code
);

  // input register
  logic             s1_valid, s1_valid_next;
  logic [ByteW-1:0] s1_byte;

  // result register
  logic out_valid_next;
  res_t out_res;

  logic s1_adv;
  logic in_xfer;
  logic res_valid;
  res_t res;

  // the byte in the input register is processed when the result slot is
  // empty or being emptied this cycle
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  cbor_hdr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (s1_adv),
    .data_byte (s1_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    s1_valid_next = s1_valid;
    if (in_xfer) begin
      s1_valid_next = 1'b1;
    end else if (s1_adv) begin
      s1_valid_next = 1'b0;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (s1_adv && res_valid) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte <= data_byte;
    end
    if (s1_adv && res_valid) begin
      out_res <= res;
    end
  end

  assign item_kind    = out_res.kind;
  assign indef_length = out_res.indef;
  assign item_value   = out_res.value;
  assign error_code   = out_res.err;

`ifndef NO_ASSERTIONS
  a_stall_has_byte: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked byte");

  a_byte_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_byte))
    else $error("blocked byte lost from input register");

  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !(s1_adv && res_valid) |=> !out_valid)
    else $error("result repeated after transfer");
`endif

endmodule

/* sv/cbor_hdr_core.sv */
// ----------------------------------------------------------------------------
// cbor_hdr_core
// header split, argument byte collection and result formation for one byte
// ----------------------------------------------------------------------------
module cbor_hdr_core
  import cbor_hdr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [ByteW-1:0] data_byte,
  output logic             res_valid,
  output res_t             res
);

  logic [LeftW-1:0]  bytes_left, bytes_left_next;
  logic [ValueW-1:0] arg_accum, arg_accum_next;
  logic [2:0]        held_major, held_major_next;
  logic [4:0]        held_minor, held_minor_next;

  logic [2:0]        major;
  logic [4:0]        minor;
  logic [ValueW-1:0] shifted;

  // result of a header whose argument is complete
  function automatic res_t finish(logic [2:0] maj, logic [4:0] mnr, logic [ValueW-1:0] arg);
    res_t r;
    r.kind  = {1'b0, maj};
    r.indef = 1'b0;
    r.value = arg;
    r.err   = ERR_NONE;
    if (maj == MAJ_SIMPLE) begin
      if (mnr > MinorOne) begin
        r.value = '0;
        r.err   = ERR_FLOAT;
      end
    end else if (maj == MAJ_NEGINT) begin
      if (arg[ValueW-1]) begin
        r.value = '0;
        r.err   = ERR_RANGE;
      end else begin
        r.value = ~arg;
      end
    end
    return r;
  endfunction

  assign major   = data_byte[7:5];
  assign minor   = data_byte[4:0];
  assign shifted = {arg_accum[ValueW-ByteW-1:0], data_byte};

  always_comb begin
    bytes_left_next = bytes_left;
    arg_accum_next  = arg_accum;
    held_major_next = held_major;
    held_minor_next = held_minor;
    res_valid       = 1'b0;
    res.kind        = {1'b0, major};
    res.indef       = 1'b0;
    res.value       = '0;
    res.err         = ERR_NONE;
    if (fire) begin
      priority if (bytes_left != '0) begin
        // argument byte, most significant first
        bytes_left_next = bytes_left - 4'd1;
        if (bytes_left == 4'd1) begin
          arg_accum_next = '0;
          res_valid      = 1'b1;
          res            = finish(held_major, held_minor, shifted);
        end else begin
          arg_accum_next = shifted;
        end
      end else if (data_byte == BreakByte) begin
        res_valid = 1'b1;
        res.kind  = KindBreak;
      end else begin
        held_major_next = major;
        held_minor_next = minor;
        arg_accum_next  = '0;
        priority if (minor <= ShortMax) begin
          res_valid = 1'b1;
          res       = finish(major, minor, {{(ValueW-5){1'b0}}, minor});
        end else if (minor <= MinorEight) begin
          // 24..27 -> 1, 2, 4, 8 argument bytes
          bytes_left_next = 4'd1 << minor[1:0];
        end else if (minor != MinorIndef) begin
          res_valid = 1'b1;
          res.err   = ERR_PARSE;
        end else begin
          res_valid = 1'b1;
          if (major >= MAJ_BYTES && major <= MAJ_MAP) begin
            res.indef = 1'b1;
          end else begin
            res.err = ERR_INDEF;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      arg_accum  <= '0;
      held_major <= '0;
      held_minor <= '0;
    end else begin
      bytes_left <= bytes_left_next;
      arg_accum  <= arg_accum_next;
      held_major <= held_major_next;
      held_minor <= held_minor_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_left_max: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= MaxArgBytes)
    else $error("argument byte count above eight");

  a_collect_quiet: assert property (@(posedge clk) disable iff (rst)
    fire && bytes_left > 4'd1 |-> !res_valid && bytes_left_next == bytes_left - 4'd1)
    else $error("argument byte produced a result too early");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.err != ERR_NONE |-> res.value == '0 && !res.indef)
    else $error("error result carries a value");
`endif

endmodule

/* sim/cbor_item_header_decoder_top_test.sv */
// ----------------------------------------------------------------------------
// cbor_item_header_decoder_top_test
// self-checking bench for the cbor item header decoder
// ----------------------------------------------------------------------------
// Bytes go in one transfer at a time. After each accepted byte a local model
// of the decoder works out the header result that the byte completes, if
// any, and queues it. Every result transfer is compared field by field with
// the oldest queued header. A directed part covers short forms, argument
// lengths, reserved and indefinite encodings, floats, simple values and
// break. Random phases follow with different idle and stall patterns, and
// one long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module cbor_item_header_decoder_top_test;
  import cbor_hdr_pkg::*;

  localparam int unsigned ClkHalf    = 4;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainPad   = 16;
  localparam int unsigned HoldCycles = 300;

  // dut inputs start at known values
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic [ByteW-1:0]  data_byte = '0;
  logic              out_stall = 1'b0;

  logic              in_stall;
  logic              out_valid;
  logic [KindW-1:0]  item_kind;
  logic              indef_length;
  logic [ValueW-1:0] item_value;
  logic [ErrW-1:0]   error_code;

  // headers still owed by the block, oldest first
  res_t pending_headers[$];
  res_t want;

  int unsigned err_count     = 0;
  int unsigned cycle_count   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_left     = 0;

  // local decoder state, mirrors what the block holds between bytes
  logic [LeftW-1:0]  arg_left  = '0;
  logic [ValueW-1:0] arg_bits  = '0;
  major_t            hdr_major = MAJ_UINT;
  logic [4:0]        hdr_minor = '0;

  cbor_item_header_decoder_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .item_kind    (item_kind),
    .indef_length (indef_length),
    .item_value   (item_value),
    .error_code   (error_code)
  );

  initial begin
    forever #ClkHalf clk = ~clk;
  end

  // result of a header whose argument is complete
  function automatic res_t header_result(input major_t m, input logic [4:0] minor,
                                         input logic [ValueW-1:0] arg);
    res_t r;
    r.kind  = KindW'(m);
    r.indef = 1'b0;
    r.value = arg;
    r.err   = ERR_NONE;
    if (m == MAJ_SIMPLE && minor > MinorOne) begin
      // half, single and double floats are not decoded
      r.value = '0;
      r.err   = ERR_FLOAT;
    end else if (m == MAJ_NEGINT) begin
      if (arg[ValueW-1]) begin
        // -1 - arg does not fit in 64 signed bits
        r.value = '0;
        r.err   = ERR_RANGE;
      end else begin
        r.value = ~arg;
      end
    end
    return r;
  endfunction

  // advance the local decoder by one byte; returns 1 when a header is done
  function automatic bit decode_byte(input logic [ByteW-1:0] b, output res_t r);
    logic [4:0] minor;
    r = '0;
    if (arg_left != '0) begin
      // argument bytes, most significant first
      arg_bits = {arg_bits[ValueW-ByteW-1:0], b};
      arg_left = arg_left - LeftW'(1);
      if (arg_left != '0) return 1'b0;
      r = header_result(hdr_major, hdr_minor, arg_bits);
      arg_bits = '0;
      return 1'b1;
    end
    if (b == BreakByte) begin
      r.kind = KindBreak;
      return 1'b1;
    end
    minor     = b[4:0];
    hdr_major = major_t'(b[7:5]);
    hdr_minor = minor;
    arg_bits  = '0;
    if (minor <= ShortMax) begin
      r = header_result(hdr_major, minor, ValueW'(minor));
      return 1'b1;
    end
    if (minor <= MinorEight) begin
      // 1, 2, 4 or 8 argument bytes follow
      arg_left = LeftW'(1) << (minor - MinorOne);
      return 1'b0;
    end
    r.kind = KindW'(hdr_major);
    if (minor != MinorIndef) begin
      r.err = ERR_PARSE;
    end else if (hdr_major >= MAJ_BYTES && hdr_major <= MAJ_MAP) begin
      r.indef = 1'b1;
    end else begin
      r.err = ERR_INDEF;
    end
    return 1'b1;
  endfunction

  // one input transfer, with random idle cycles in front of it
  task automatic send_byte(input logic [ByteW-1:0] b);
    res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (decode_byte(b, r)) pending_headers.push_back(r);
    bytes_sent++;
  endtask

  // mostly well-formed headers with random arguments, some noise and
  // truncated arguments mixed in
  task automatic send_random_items(input int unsigned n_bytes);
    int unsigned first;
    int unsigned pick;
    int unsigned nargs;
    int unsigned fill;
    logic [2:0]  maj;
    logic [4:0]  minor;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_byte(ByteW'($urandom));
      end else if (pick < 14) begin
        send_byte(BreakByte);
      end else begin
        maj  = 3'($urandom);
        pick = $urandom_range(99);
        if (pick < 35)      minor = 5'($urandom_range(23));
        else if (pick < 85) minor = 5'($urandom_range(27, 24));
        else if (pick < 93) minor = MinorIndef;
        else                minor = 5'($urandom_range(30, 28));
        send_byte({maj, minor});
        if (minor >= MinorOne && minor <= MinorEight) begin
          nargs = 1 << (minor - MinorOne);
          // now and then cut the argument short
          if ($urandom_range(19) == 0) nargs = $urandom_range(nargs - 1);
          fill = $urandom_range(3);
          for (int i = 0; i < nargs; i++) begin
            if (fill == 1) begin
              send_byte(8'hFF);
            end else if (fill == 2) begin
              send_byte(8'h00);
            end else if (fill == 3 && i == 0 && maj == MAJ_NEGINT) begin
              // straddle the negint range limit
              send_byte($urandom_range(1) ? 8'h7F : 8'h80);
            end else begin
              send_byte(ByteW'($urandom));
            end
          end
        end
      end
    end
  endtask

  task automatic test_short_forms;
    send_byte(8'h00);    // uint 0
    send_byte(8'h17);    // uint 23, largest short form
    send_byte(8'hC0);    // tag 0
  endtask

  task automatic test_arguments;
    send_byte(8'h18);    // uint, one argument byte
    send_byte(8'hFF);
    send_byte(8'h3B);    // negint, eight bytes, top bit set: out of range
    send_byte(8'h80);
    repeat (7) send_byte(8'h00);
  endtask

  task automatic test_errors;
    send_byte(8'h1C);    // reserved additional info on uint
    send_byte(8'hBE);    // reserved additional info on map
    send_byte(8'h1F);    // indefinite uint is not allowed
    send_byte(8'h5F);    // indefinite byte string
  endtask

  task automatic test_simple_and_break;
    send_byte(8'hF8);    // simple value in one extra byte
    send_byte(8'hFF);    // argument byte, not a break
    send_byte(8'hF9);    // half float, payload still consumed
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(BreakByte);
  endtask

  task automatic test_random_phase(input int unsigned idle, input int unsigned stall,
                                   input int unsigned n_bytes);
    send_idle_pct = idle;
    stall_pct     = stall;
    send_random_items(n_bytes);
  endtask

  // output held off for a long stretch while the input keeps offering bytes
  task automatic test_backpressure;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = HoldCycles;
    send_random_items(40);
  endtask

  // output stall: a counted hold-off when asked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare every result transfer with the oldest pending header
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_headers.size() == 0) begin
        $display("%0t: unexpected result: kind %0d indef %0b value %h err %0d", $time,
                 item_kind, indef_length, item_value, error_code);
        err_count++;
      end else begin
        want = pending_headers.pop_front();
        if (item_kind !== want.kind) begin
          $display("%0t: item_kind expected %0d actual %0d", $time, want.kind, item_kind);
          err_count++;
        end
        if (indef_length !== want.indef) begin
          $display("%0t: indef_length expected %0b actual %0b", $time, want.indef,
                   indef_length);
          err_count++;
        end
        if (item_value !== want.value) begin
          $display("%0t: item_value expected %h actual %h", $time, want.value, item_value);
          err_count++;
        end
        if (error_code !== want.err) begin
          $display("%0t: error_code expected %0d actual %0d", $time, want.err, error_code);
          err_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("cbor_item_header_decoder_top_test: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_forms();
    test_arguments();
    test_errors();
    test_simple_and_break();

    // no idling, idle sender, stalling receiver, then light idling on both
    test_random_phase(0, 0, 225);
    test_random_phase(80, 0, 225);
    test_random_phase(0, 80, 225);
    test_random_phase(9, 9, 225);
    test_backpressure();

    // stop offering in the same step as the last transfer
    in_valid  <= 1'b0;
    stall_pct = 0;
    while (pending_headers.size() != 0) @(posedge clk);
    repeat (DrainPad) @(posedge clk);

    if (err_count == 0) begin
      $display("cbor_item_header_decoder_top_test: done, clean");
    end else begin
      $display("cbor_item_header_decoder_top_test: done, errors");
    end
    $finish;
  end

endmodule
